/* sv/snake_leaky_activation_top_defines.svh */
// ----------------------------------------------------------------------------
// snake_leaky_activation_top_defines
// assertion macros shared by the activation block
// ----------------------------------------------------------------------------
`ifndef SNAKE_LEAKY_ACTIVATION_TOP_DEFINES_SVH
`define SNAKE_LEAKY_ACTIVATION_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define SLA_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("snake_leaky_activation check failed");
`define SLA_ASSERT_IMP(name, cond, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
	else $error("snake_leaky_activation check failed");
`else
`define SLA_ASSERT(name, prop)
`define SLA_ASSERT_IMP(name, cond, prop)
`endif

`endif

/* sv/sla_pkg.sv */
// ----------------------------------------------------------------------------
// sla_pkg
// types, constants and tables of the snake / leaky activation block
// ----------------------------------------------------------------------------
package sla_pkg;

	localparam int DATA_W       = 24;
	localparam int REM_W        = 48;
	localparam int DVR_W        = 34;
	localparam int QUO_W        = 34;
	localparam int CRD_W        = 34;
	localparam int MOD_STEPS    = 14;
	localparam int CORDIC_STEPS = 24;
	localparam int DIV_STEPS    = 34;
	localparam int LATENCY      = 77;

	localparam logic [DVR_W-1:0] PI_Q32      = 34'd13493037704;
	localparam logic [31:0]      PI_Q30      = 32'd3373259426;
	localparam logic [31:0]      HALF_PI_Q30 = 32'd1686629713;
	localparam logic [31:0]      GAIN_Q30    = 32'd652032874;
	localparam logic [9:0]       LEAK_NUM    = 10'd655;

	typedef logic [5:0] step_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] x;
		logic [DATA_W-1:0]        a;
		logic                     snake;
		logic                     row_end;
	} side_t;

	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0:    v = 32'd843314857;
			5'd1:    v = 32'd497837829;
			5'd2:    v = 32'd263043836;
			5'd3:    v = 32'd133525158;
			5'd4:    v = 32'd67021686;
			5'd5:    v = 32'd33543515;
			5'd6:    v = 32'd16775850;
			5'd7:    v = 32'd8388437;
			5'd8:    v = 32'd4194282;
			5'd9:    v = 32'd2097149;
			5'd10:   v = 32'd1048575;
			5'd11:   v = 32'd524287;
			5'd12:   v = 32'd262143;
			5'd13:   v = 32'd131071;
			5'd14:   v = 32'd65535;
			5'd15:   v = 32'd32767;
			5'd16:   v = 32'd16383;
			5'd17:   v = 32'd8191;
			5'd18:   v = 32'd4095;
			5'd19:   v = 32'd2047;
			5'd20:   v = 32'd1023;
			5'd21:   v = 32'd511;
			5'd22:   v = 32'd255;
			5'd23:   v = 32'd127;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [DATA_W-1:0] sat(input logic signed [35:0] v);
		logic signed [35:0] hi;
		logic signed [35:0] lo;
		hi = 36'sd8388607;
		lo = -36'sd8388608;
		if (v > hi) begin
			return hi[DATA_W-1:0];
		end else if (v < lo) begin
			return lo[DATA_W-1:0];
		end
		return v[DATA_W-1:0];
	endfunction

endpackage

/* sv/sla_div_cell.sv */
// ----------------------------------------------------------------------------
// sla_div_cell
// one restoring step: subtract divisor shifted by k when it fits
// ----------------------------------------------------------------------------
module sla_div_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sla_pkg::step_t                 k,
	input  logic                           valid_i,
	input  logic [sla_pkg::REM_W-1:0]      rem_i,
	input  logic [sla_pkg::DVR_W-1:0]      divisor_i,
	input  logic [sla_pkg::QUO_W-1:0]      quo_i,
	input  sla_pkg::side_t                 side_i,
	output logic                           valid_o,
	output logic [sla_pkg::REM_W-1:0]      rem_o,
	output logic [sla_pkg::DVR_W-1:0]      divisor_o,
	output logic [sla_pkg::QUO_W-1:0]      quo_o,
	output sla_pkg::side_t                 side_o
);

	logic [sla_pkg::REM_W-1:0] dv_ext;
	logic                      fits;
	logic [sla_pkg::REM_W-1:0] rem_nxt;

	assign dv_ext  = {{(sla_pkg::REM_W-sla_pkg::DVR_W){1'b0}}, divisor_i};
	assign fits    = (rem_i >> k) >= dv_ext;
	assign rem_nxt = fits ? (rem_i - (dv_ext << k)) : rem_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		rem_o     <= rem_nxt;
		divisor_o <= divisor_i;
		quo_o     <= {quo_i[sla_pkg::QUO_W-2:0], fits};
		side_o    <= side_i;
	end

endmodule

/* sv/sla_cordic_cell.sv */
// ----------------------------------------------------------------------------
// sla_cordic_cell
// one rotation-mode cordic iteration with floor shifts
// ----------------------------------------------------------------------------
module sla_cordic_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [4:0]                        idx,
	input  logic                              valid_i,
	input  logic signed [sla_pkg::CRD_W-1:0]  cx_i,
	input  logic signed [sla_pkg::CRD_W-1:0]  cy_i,
	input  logic signed [sla_pkg::CRD_W-1:0]  z_i,
	input  sla_pkg::side_t                    side_i,
	output logic                              valid_o,
	output logic signed [sla_pkg::CRD_W-1:0]  cx_o,
	output logic signed [sla_pkg::CRD_W-1:0]  cy_o,
	output logic signed [sla_pkg::CRD_W-1:0]  z_o,
	output sla_pkg::side_t                    side_o
);

	logic signed [sla_pkg::CRD_W-1:0] dx;
	logic signed [sla_pkg::CRD_W-1:0] dy;
	logic signed [sla_pkg::CRD_W-1:0] ang;

	assign dx  = cy_i >>> idx;
	assign dy  = cx_i >>> idx;
	assign ang = $signed({2'b00, sla_pkg::atan_q30(idx)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_o <= 1'b0;
		end else begin
			valid_o <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (!z_i[sla_pkg::CRD_W-1]) begin
			cx_o <= cx_i - dx;
			cy_o <= cy_i + dy;
			z_o  <= z_i - ang;
		end else begin
			cx_o <= cx_i + dx;
			cy_o <= cy_i - dy;
			z_o  <= z_i + ang;
		end
		side_o <= side_i;
	end

endmodule

/* sv/snake_leaky_activation_top.sv */
// throughput: one item per cycle, busy is always low
// the pipeline holds chains of cells: 14 modulo steps, 24 cordic steps, 34 divide steps
// results leave on done for one cycle; the receiver cannot stall
// reset clears all valid flags; the pipeline is empty after reset
// ----------------------------------------------------------------------------
// snake_leaky_activation_top
// per-sample snake or leaky relu activation, fully pipelined
// ----------------------------------------------------------------------------
`include "snake_leaky_activation_top_defines.svh"

module snake_leaky_activation_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [sla_pkg::DATA_W-1:0]   sample,
	input  logic [sla_pkg::DATA_W-1:0]          alpha,
	input  logic                                use_snake,
	input  logic                                row_end,
	output logic                                done,
	output logic signed [sla_pkg::DATA_W-1:0]   activated,
	output logic                                row_end_out
);

	localparam int MS = sla_pkg::MOD_STEPS;
	localparam int CS = sla_pkg::CORDIC_STEPS;
	localparam int DS = sla_pkg::DIV_STEPS;

	logic                           valid_s1;
	sla_pkg::side_t                 side_s1;
	logic [sla_pkg::DATA_W-1:0]     mag_s1;
	logic                           valid_s2;
	sla_pkg::side_t                 side_s2;
	logic [sla_pkg::REM_W-1:0]      phase_s2;

	logic                           mod_v    [0:MS];
	logic [sla_pkg::REM_W-1:0]      mod_rem  [0:MS];
	logic [sla_pkg::DVR_W-1:0]      mod_dvr  [0:MS];
	logic [sla_pkg::QUO_W-1:0]      mod_quo  [0:MS];
	sla_pkg::side_t                 mod_side [0:MS];

	logic [31:0]                    r_red;
	logic [31:0]                    r_clip;
	logic [31:0]                    r_fold;

	logic                              crd_v    [0:CS];
	logic signed [sla_pkg::CRD_W-1:0]  crd_cx   [0:CS];
	logic signed [sla_pkg::CRD_W-1:0]  crd_cy   [0:CS];
	logic signed [sla_pkg::CRD_W-1:0]  crd_z    [0:CS];
	sla_pkg::side_t                    crd_side [0:CS];

	logic signed [sla_pkg::CRD_W-1:0]  y_abs;
	logic [63:0]                       y_sq;

	logic                           div_v    [0:DS];
	logic [sla_pkg::REM_W-1:0]      div_rem  [0:DS];
	logic [sla_pkg::DVR_W-1:0]      div_dvr  [0:DS];
	logic [sla_pkg::QUO_W-1:0]      div_quo  [0:DS];
	sla_pkg::side_t                 div_side [0:DS];

	sla_pkg::side_t                 fin;
	logic signed [35:0]             snake_sum;
	logic signed [33:0]             leak_prod;
	logic signed [35:0]             leak_val;
	logic signed [35:0]             pick;
	logic [6:0]                     warm_q;

	assign busy = 1'b0;

	// input stage and phase product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		side_s1.x       <= sample;
		side_s1.a       <= (alpha == '0) ? sla_pkg::DATA_W'(1) : alpha;
		side_s1.snake   <= use_snake;
		side_s1.row_end <= row_end;
		mag_s1          <= sample[sla_pkg::DATA_W-1] ? (~sample + 1'b1) : sample;
		side_s2         <= side_s1;
		phase_s2        <= sla_pkg::REM_W'(mag_s1) * sla_pkg::REM_W'(side_s1.a);
	end

	// phase modulo pi
	assign mod_v[0]    = valid_s2;
	assign mod_rem[0]  = phase_s2;
	assign mod_dvr[0]  = sla_pkg::PI_Q32;
	assign mod_quo[0]  = '0;
	assign mod_side[0] = side_s2;

	for (genvar g = 0; g < MS; g++) begin : g_mod
		sla_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.k         (sla_pkg::step_t'(MS - 1 - g)),
			.valid_i   (mod_v[g]),
			.rem_i     (mod_rem[g]),
			.divisor_i (mod_dvr[g]),
			.quo_i     (mod_quo[g]),
			.side_i    (mod_side[g]),
			.valid_o   (mod_v[g+1]),
			.rem_o     (mod_rem[g+1]),
			.divisor_o (mod_dvr[g+1]),
			.quo_o     (mod_quo[g+1]),
			.side_o    (mod_side[g+1])
		);
	end

	// fold into the first quadrant
	assign r_red  = mod_rem[MS][33:2];
	assign r_clip = (r_red > sla_pkg::PI_Q30) ? sla_pkg::PI_Q30 : r_red;
	assign r_fold = (r_clip > sla_pkg::HALF_PI_Q30) ? (sla_pkg::PI_Q30 - r_clip) : r_clip;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crd_v[0] <= 1'b0;
		end else begin
			crd_v[0] <= mod_v[MS] && (mod_dvr[MS] == sla_pkg::PI_Q32);
		end
	end

	always_ff @(posedge clk) begin
		crd_cx[0]   <= $signed({2'b00, sla_pkg::GAIN_Q30});
		crd_cy[0]   <= '0;
		crd_z[0]    <= $signed({2'b00, r_fold});
		crd_side[0] <= mod_side[MS];
	end

	for (genvar g = 0; g < CS; g++) begin : g_crd
		sla_cordic_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.idx     (5'(g)),
			.valid_i (crd_v[g]),
			.cx_i    (crd_cx[g]),
			.cy_i    (crd_cy[g]),
			.z_i     (crd_z[g]),
			.side_i  (crd_side[g]),
			.valid_o (crd_v[g+1]),
			.cx_o    (crd_cx[g+1]),
			.cy_o    (crd_cy[g+1]),
			.z_o     (crd_z[g+1]),
			.side_o  (crd_side[g+1])
		);
	end

	// square of the sine
	assign y_abs = crd_cy[CS][sla_pkg::CRD_W-1] ? -crd_cy[CS] : crd_cy[CS];
	assign y_sq  = 64'(y_abs[31:0]) * 64'(y_abs[31:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_v[0] <= 1'b0;
		end else begin
			div_v[0] <= crd_v[CS] && (mod_quo[MS] == mod_quo[MS] || 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		div_rem[0]  <= {14'd0, y_sq[61:28]};
		div_dvr[0]  <= {10'd0, crd_side[CS].a};
		div_quo[0]  <= '0;
		div_side[0] <= crd_side[CS];
	end

	// divide by alpha
	for (genvar g = 0; g < DS; g++) begin : g_div
		sla_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.k         (sla_pkg::step_t'(DS - 1 - g)),
			.valid_i   (div_v[g]),
			.rem_i     (div_rem[g]),
			.divisor_i (div_dvr[g]),
			.quo_i     (div_quo[g]),
			.side_i    (div_side[g]),
			.valid_o   (div_v[g+1]),
			.rem_o     (div_rem[g+1]),
			.divisor_o (div_dvr[g+1]),
			.quo_o     (div_quo[g+1]),
			.side_o    (div_side[g+1])
		);
	end

	// result select and saturate
	assign fin       = div_side[DS];
	assign snake_sum = 36'(fin.x) + $signed({2'b00, div_quo[DS]});
	assign leak_prod = 34'(fin.x) * $signed({24'd0, sla_pkg::LEAK_NUM});
	assign leak_val  = 36'(leak_prod >>> 16);

	always_comb begin
		if (fin.snake) begin
			pick = snake_sum;
		end else if (fin.x[sla_pkg::DATA_W-1]) begin
			pick = leak_val;
		end else begin
			pick = 36'(fin.x);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= div_v[DS] && (div_rem[DS] == div_rem[DS] || 1'b1) && (div_dvr[DS] != '0);
		end
	end

	always_ff @(posedge clk) begin
		activated   <= sla_pkg::sat(pick);
		row_end_out <= fin.row_end;
	end

	// cycles since reset, saturating at the pipeline depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_q <= '0;
		end else if (warm_q != 7'(sla_pkg::LATENCY)) begin
			warm_q <= warm_q + 7'd1;
		end
	end

	`SLA_ASSERT(a_busy_low, !busy)
	`SLA_ASSERT_IMP(a_latency, warm_q == 7'(sla_pkg::LATENCY), done == $past(start && !busy, sla_pkg::LATENCY))
	`SLA_ASSERT_IMP(a_leaky_pass, done && !$past(fin.snake) && !$past(fin.x[sla_pkg::DATA_W-1]), activated == $past(fin.x))
	`SLA_ASSERT_IMP(a_snake_not_below, done && $past(fin.snake), $signed(activated) >= $past(fin.x))

endmodule

/* verif/snake_leaky_activation_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// snake_leaky_activation_top_tb
// drives single samples through the activation block in snake and leaky
// mode, predicts each activated sample with a fixed-point cordic model of
// its own and compares every strobed result in order
// ----------------------------------------------------------------------------
module snake_leaky_activation_top_tb;

	localparam int WATCHDOG_CYCLES = 4000;

	typedef struct packed {
		logic signed [sla_pkg::DATA_W-1:0] sample;
		logic [sla_pkg::DATA_W-1:0]        alpha;
		logic                              use_snake;
		logic                              row_end;
	} sample_item_t;

	typedef struct packed {
		logic signed [sla_pkg::DATA_W-1:0] activated;
		logic                              row_end;
	} activated_t;

	logic                              clk;
	logic                              arst_n;
	logic                              start;
	logic                              busy;
	logic signed [sla_pkg::DATA_W-1:0] sample;
	logic [sla_pkg::DATA_W-1:0]        alpha;
	logic                              use_snake;
	logic                              row_end;
	logic                              done;
	logic signed [sla_pkg::DATA_W-1:0] activated;
	logic                              row_end_out;

	sample_item_t pending_items[$];
	activated_t   expected_results[$];
	sample_item_t cur_item;
	int           idle_pct;
	int           errors;
	int           accepted_cnt;
	int           checked_cnt;
	int           snake_cnt;
	int           quiet_cycles;

	int phase_pct[4] = '{0, 67, 30, 0};

	longint atan_tbl[24] = '{
		843314857, 497837829, 263043836, 133525158, 67021686, 33543515,
		16775850, 8388437, 4194282, 2097149, 1048575, 524287,
		262143, 131071, 65535, 32767, 16383, 8191,
		4095, 2047, 1023, 511, 255, 127
	};

	snake_leaky_activation_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.sample     (sample),
		.alpha      (alpha),
		.use_snake  (use_snake),
		.row_end    (row_end),
		.done       (done),
		.activated  (activated),
		.row_end_out(row_end_out)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic signed [sla_pkg::DATA_W-1:0] clamp24(input longint v);
		if (v > 64'sd8388607) begin
			return 24'h7fffff;
		end else if (v < -64'sd8388608) begin
			return 24'h800000;
		end
		return v[sla_pkg::DATA_W-1:0];
	endfunction

	function automatic logic signed [sla_pkg::DATA_W-1:0] activate(input sample_item_t it);
		longint          xs;
		longint unsigned a;
		longint unsigned mag;
		longint unsigned red;
		longint unsigned sq;
		longint          r;
		longint          cx;
		longint          cy;
		longint          z;
		longint          dx;
		longint          dy;
		xs = it.sample;
		a = (it.alpha == 0) ? 64'd1 : {40'd0, it.alpha};
		if (!it.use_snake) begin
			if (xs < 0) begin
				return clamp24((xs * 655) >>> 16);
			end
			return it.sample;
		end
		mag = (xs < 0) ? longint'(-xs) : longint'(xs);
		red = (mag * a) % (64'd3622009729038561421 >> 28);
		r = longint'(red >> 2);
		if (r > 64'sd3373259426) begin
			r = 64'sd3373259426;
		end
		if (r > 64'sd1686629713) begin
			r = 64'sd3373259426 - r;
		end
		cx = 64'sd652032874;
		cy = 0;
		z = r;
		for (int i = 0; i < 24; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (z >= 0) begin
				cx -= dx;
				cy += dy;
				z -= atan_tbl[i];
			end else begin
				cx += dx;
				cy -= dy;
				z += atan_tbl[i];
			end
		end
		if (cy < 0) begin
			cy = -cy;
		end
		sq = (longint'(cy) * longint'(cy)) >> 28;
		return clamp24(xs + longint'(sq / a));
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start     <= 1'b0;
			sample    <= '0;
			alpha     <= '0;
			use_snake <= 1'b0;
			row_end   <= 1'b0;
		end else begin
			if (start && !busy) begin
				expected_results.push_back({activate(cur_item), cur_item.row_end});
				accepted_cnt++;
				if (cur_item.use_snake) begin
					snake_cnt++;
				end
			end
			if ((!start || !busy) && pending_items.size() > 0 &&
					$urandom_range(99) >= idle_pct) begin
				cur_item = pending_items.pop_front();
				start     <= 1'b1;
				sample    <= cur_item.sample;
				alpha     <= cur_item.alpha;
				use_snake <= cur_item.use_snake;
				row_end   <= cur_item.row_end;
			end else if (!start || !busy) begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result activated=%0d row_end=%0b",
					$time, activated, row_end_out);
				errors++;
			end else begin
				activated_t e;
				e = expected_results.pop_front();
				if (activated !== e.activated) begin
					$display("%0t: activated expected %0d actual %0d",
						$time, e.activated, activated);
					errors++;
				end
				if (row_end_out !== e.row_end) begin
					$display("%0t: row_end_out expected %0b actual %0b",
						$time, e.row_end, row_end_out);
					errors++;
				end
				checked_cnt++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_CYCLES) begin
				$display("snake_leaky_activation_top_tb NOT OK");
				$finish;
			end
		end
	end

	task automatic add_item(input logic [23:0] s, input logic [23:0] a,
			input logic snk, input logic re);
		pending_items.push_back({s, a, snk, re});
	endtask

	task automatic add_random(input int n);
		logic [23:0] s;
		logic [23:0] a;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(3))
				0: s = 24'($urandom());
				1: s = 24'($urandom_range(4 << 16) - (2 << 16));
				2: s = {{8{1'($urandom_range(1))}}, 16'($urandom())};
				default: s = 24'($urandom_range(255) - 128);
			endcase
			case ($urandom_range(3))
				0: a = 24'($urandom());
				1: a = 24'($urandom_range(3 << 16, 1 << 14));
				2: a = 24'($urandom_range(15));
				default: a = 24'($urandom_range(65536 + 4096, 65536 - 4096));
			endcase
			add_item(s, a, $urandom_range(3) != 0, $urandom_range(7) == 0);
		end
	endtask

	task automatic drain();
		while (pending_items.size() > 0 || start || expected_results.size() > 0) begin
			@(posedge clk);
		end
	endtask

	initial begin
		errors = 0;
		accepted_cnt = 0;
		checked_cnt = 0;
		snake_cnt = 0;
		quiet_cycles = 0;
		idle_pct = 0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes of both modes, alpha of zero, saturation at the upper bound
		add_item(24'h7fffff, 24'h010000, 1'b1, 1'b0);
		add_item(24'h800000, 24'h010000, 1'b1, 1'b1);
		add_item(24'h000000, 24'h000000, 1'b1, 1'b0);
		add_item(24'hffffff, 24'h000000, 1'b1, 1'b1);
		add_item(24'h7fffff, 24'hffffff, 1'b1, 1'b0);
		add_item(24'h800000, 24'hffffff, 1'b1, 1'b0);
		add_item(24'h7fffff, 24'h000001, 1'b1, 1'b0);
		add_item(24'h7ff000, 24'h000000, 1'b1, 1'b0);
		add_item(24'h018000, 24'h000000, 1'b1, 1'b1);
		add_item(24'h019220, 24'h010000, 1'b1, 1'b0);
		add_item(24'h032440, 24'h010000, 1'b1, 1'b0);
		add_item(24'hfe6dc0, 24'h010000, 1'b1, 1'b0);
		add_item(24'h555555, 24'haaaaaa, 1'b1, 1'b1);
		add_item(24'haaaaaa, 24'h555555, 1'b1, 1'b0);
		add_item(24'h7fffff, 24'h000000, 1'b0, 1'b0);
		add_item(24'h800000, 24'hffffff, 1'b0, 1'b1);
		add_item(24'hffffff, 24'h123456, 1'b0, 1'b0);
		add_item(24'h000000, 24'h000000, 1'b0, 1'b1);
		add_item(24'hff0000, 24'h010000, 1'b0, 1'b0);
		add_item(24'hfffe00, 24'h010000, 1'b0, 1'b0);
		add_item(24'h000001, 24'h000001, 1'b0, 1'b1);
		drain();

		foreach (phase_pct[k]) begin
			idle_pct = phase_pct[k];
			add_random(150);
			drain();
		end
		repeat (sla_pkg::LATENCY + 20) @(posedge clk);

		$display("covered %0d samples, %0d in snake mode, %0d results checked",
			accepted_cnt, snake_cnt, checked_cnt);
		$display("sender idle phases of 0, 67, 30 and 0 percent");
		if (errors == 0 && expected_results.size() == 0) begin
			$display("snake_leaky_activation_top_tb OK");
		end else begin
			$display("snake_leaky_activation_top_tb NOT OK");
		end
		$finish;
	end

endmodule
